// ----- rtl/core/pbt_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pbt_pkg: shared types and constants of the port binding table
// Request and result words, codes, controller states and the command and
// status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package pbt_pkg;

  // Default sizes
  localparam int PORT_BITS_DEF      = 16;
  localparam int SOCKET_ID_BITS_DEF = 16;

  // Occupancy row: ports per row and summary flags per summary row (log2)
  localparam int COL_BITS      = 6;
  localparam int SUMW_MAX_BITS = 6;

  // Field widths of the request and result words
  localparam int FIELD_W = 16;

  // Configuration register reset values
  localparam logic [FIELD_W-1:0] EPH_LOW_RESET  = 16'd49152;
  localparam logic [FIELD_W-1:0] EPH_HIGH_RESET = 16'd65534;

  // Configuration port
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_W    = 32;

  typedef enum logic [1:0] {
    REQ_LOOKUP    = 2'd0,
    REQ_BIND      = 2'd1,
    REQ_EPHEMERAL = 2'd2,
    REQ_UNBIND    = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_IN_USE    = 2'd1,
    ST_NOT_BOUND = 2'd2
  } status_e;

  typedef struct packed {
    req_e               req_type;
    logic [FIELD_W-1:0] port_number;
    logic [FIELD_W-1:0] socket_handle;
  } pbt_req_t;

  typedef struct packed {
    status_e            status;
    logic [FIELD_W-1:0] bound_port;
    logic [FIELD_W-1:0] found_socket;
  } pbt_rsp_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CHECK,
    S_SRCH_RD,
    S_SRCH,
    S_SUM_RD,
    S_SUM_WR,
    S_FINISH
  } pbt_state_e;

  // Controller to datapath
  typedef struct packed {
    logic    clr_wr;        // clear one occupancy row, advance sweep
    logic    load;          // capture the accepted request word
    logic    occ_rd;        // read occupancy row and socket entry
    logic    take;          // mark target port bound, store socket
    logic    drop;          // mark request port free
    logic    row_inc;       // step to the next occupancy row
    logic    row_from_sum;  // jump to the row the summary search found
    logic    row_from_top;  // jump to the summary row the top search found
    logic    sum_rd;        // read the summary row of the working row
    logic    sum_wr;        // update summary row and top flag
    logic    set_res;       // latch result code
    status_e res_status;
    logic    res_found;     // report the stored socket
    logic    res_zero_port; // report port zero
    logic    emit;          // load the output register
  } pbt_cmd_t;

  // Datapath to controller
  typedef struct packed {
    req_e req;
    logic clr_done;
    logic bit_set;
    logic free_found;
    logic cand_ok;
    logic win_empty;
    logic last_row;
    logic sum_found;
    logic top_found;
    logic out_busy;
  } pbt_stat_t;

endpackage
`default_nettype wire

// ----- rtl/core/pbt_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pbt_ctrl: request sequencer of the port binding table
// Runs the clearing sweep after reset, then steps each request through
// occupancy reads, the hierarchical free-port search and the summary update.
// ----------------------------------------------------------------------------
module pbt_ctrl import pbt_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire pbt_stat_t stat_i,
  output pbt_cmd_t       cmd_o
);

  pbt_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d            = state_q;
    cmd_o              = '0;
    cmd_o.res_status   = ST_OK;
    in_ready_o         = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.clr_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_READ;
        end
      end
      S_READ: begin
        cmd_o.occ_rd = 1'b1;
        state_d      = S_CHECK;
      end
      S_CHECK: begin
        cmd_o.set_res = 1'b1;
        case (stat_i.req)
          REQ_LOOKUP: begin
            cmd_o.res_status = stat_i.bit_set ? ST_OK : ST_NOT_BOUND;
            cmd_o.res_found  = stat_i.bit_set;
            state_d          = S_FINISH;
          end
          REQ_BIND: begin
            if (stat_i.bit_set) begin
              cmd_o.res_status = ST_IN_USE;
              state_d          = S_FINISH;
            end else begin
              cmd_o.take = 1'b1;
              state_d    = S_SUM_RD;
            end
          end
          REQ_UNBIND: begin
            cmd_o.drop = 1'b1;
            state_d    = S_SUM_RD;
          end
          default: begin
            // Ephemeral: try the current row, else move on through the summary
            if (!stat_i.win_empty && stat_i.free_found && stat_i.cand_ok) begin
              cmd_o.take = 1'b1;
              state_d    = S_SUM_RD;
            end else if (!stat_i.win_empty && !stat_i.free_found &&
                         !stat_i.last_row) begin
              cmd_o.set_res = 1'b0;
              cmd_o.row_inc = 1'b1;
              state_d       = S_SRCH_RD;
            end else begin
              cmd_o.res_status    = ST_IN_USE;
              cmd_o.res_zero_port = 1'b1;
              state_d             = S_FINISH;
            end
          end
        endcase
      end
      S_SRCH_RD: begin
        cmd_o.sum_rd = 1'b1;
        state_d      = S_SRCH;
      end
      S_SRCH: begin
        if (stat_i.sum_found) begin
          cmd_o.row_from_sum = 1'b1;
          state_d            = S_READ;
        end else if (stat_i.top_found) begin
          cmd_o.row_from_top = 1'b1;
          state_d            = S_SRCH_RD;
        end else begin
          cmd_o.set_res       = 1'b1;
          cmd_o.res_status    = ST_IN_USE;
          cmd_o.res_zero_port = 1'b1;
          state_d             = S_FINISH;
        end
      end
      S_SUM_RD: begin
        cmd_o.sum_rd = 1'b1;
        state_d      = S_SUM_WR;
      end
      S_SUM_WR: begin
        cmd_o.sum_wr = 1'b1;
        state_d      = S_FINISH;
      end
      S_FINISH: begin
        if (!stat_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/core/pbt_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pbt_datapath: storage and search logic of the port binding table
// Occupancy rows, a summary of full rows, top-level full flags, the socket
// store, the first-free searches and the output register.
// ----------------------------------------------------------------------------
module pbt_datapath import pbt_pkg::*; #(
  parameter int PORT_BITS      = PORT_BITS_DEF,
  parameter int SOCKET_ID_BITS = SOCKET_ID_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire pbt_req_t           in_data_i,
  input  wire logic [FIELD_W-1:0] eph_low_i,
  input  wire logic [FIELD_W-1:0] eph_high_i,
  input  wire pbt_cmd_t           cmd_i,
  output pbt_stat_t               stat_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output pbt_rsp_t                out_data_o
);

  localparam int ROW_W     = 1 << COL_BITS;
  localparam int ROWS_BITS = PORT_BITS - COL_BITS;
  localparam int ROWS      = 1 << ROWS_BITS;
  localparam int SUMW_BITS = (ROWS_BITS < SUMW_MAX_BITS) ? ROWS_BITS : SUMW_MAX_BITS;
  localparam int SUM_W     = 1 << SUMW_BITS;
  localparam int SR_BITS   = (ROWS_BITS > SUMW_BITS) ? (ROWS_BITS - SUMW_BITS) : 1;
  localparam int SR_N      = 1 << SR_BITS;
  localparam int SR_REAL   = 1 << (ROWS_BITS - SUMW_BITS);
  localparam int PORTS     = 1 << PORT_BITS;
  // Summary rows that do not exist read as full
  localparam logic [SR_N-1:0] TOP_INIT = ~SR_N'((1 << SR_REAL) - 1);

  // Storage
  logic [ROW_W-1:0]          occ_mem  [ROWS];
  logic [SUM_W-1:0]          sum_mem  [SR_N];
  logic [SOCKET_ID_BITS-1:0] sock_mem [PORTS];

  // Control registers
  logic [ROWS_BITS-1:0] clr_cnt_q;
  logic [SR_N-1:0]      top_full_q;
  logic                 out_valid_q;

  // Payload registers
  req_e                      req_q;
  logic [PORT_BITS-1:0]      port_q;
  logic [PORT_BITS-1:0]      lo_q;
  logic [PORT_BITS-1:0]      hi_q;
  logic [SOCKET_ID_BITS-1:0] sock_q;
  logic [ROWS_BITS-1:0]      row_q;
  logic [COL_BITS-1:0]       col_q;
  logic [ROW_W-1:0]          occ_rd_q;
  logic [SUM_W-1:0]          sum_rd_q;
  logic [SOCKET_ID_BITS-1:0] sock_rd_q;
  logic                      row_full_q;
  status_e                   res_status_q;
  logic                      res_found_q;
  logic                      res_zero_q;
  pbt_rsp_t                  out_data_q;

  // Working signals
  logic [PORT_BITS-1:0] in_port;
  logic [PORT_BITS-1:0] in_lo;
  logic [PORT_BITS-1:0] in_start;
  logic [SR_BITS-1:0]   srow;
  logic [SUMW_BITS-1:0] sbit;
  logic                 free_found;
  logic [COL_BITS-1:0]  free_idx;
  logic                 sum_found;
  logic [SUMW_BITS-1:0] sum_idx;
  logic                 top_found;
  logic [SR_BITS-1:0]   top_idx;
  logic [COL_BITS-1:0]  tgt_col;
  logic [ROW_W-1:0]     occ_wdata;
  logic [SUM_W-1:0]     sum_new;
  logic [PORT_BITS-1:0] tgt_port;

  assign in_port  = PORT_BITS'(in_data_i.port_number);
  assign in_lo    = PORT_BITS'(eph_low_i);
  assign in_start = (in_data_i.req_type == REQ_EPHEMERAL) ? in_lo : in_port;

  assign srow = SR_BITS'(row_q >> SUMW_BITS);
  assign sbit = row_q[SUMW_BITS-1:0];

  // Find the lowest free port of the row at or above the start column
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (!occ_rd_q[i] && (COL_BITS'(i) >= col_q)) begin
        free_found = 1'b1;
        free_idx   = COL_BITS'(i);
      end
    end
  end

  // Find the lowest row that is not full at or above the working row
  always_comb begin
    sum_found = 1'b0;
    sum_idx   = '0;
    for (int i = SUM_W - 1; i >= 0; i--) begin
      if (!sum_rd_q[i] && (SUMW_BITS'(i) >= sbit)) begin
        sum_found = 1'b1;
        sum_idx   = SUMW_BITS'(i);
      end
    end
  end

  // Find the lowest summary row above the current one that is not full
  always_comb begin
    top_found = 1'b0;
    top_idx   = '0;
    for (int i = SR_N - 1; i >= 0; i--) begin
      if (!top_full_q[i] && (SR_BITS'(i) > srow)) begin
        top_found = 1'b1;
        top_idx   = SR_BITS'(i);
      end
    end
  end

  // Target column: the found free port for ephemeral, else the request port
  assign tgt_col  = (req_q == REQ_EPHEMERAL) ? free_idx : col_q;
  assign tgt_port = {row_q, tgt_col};

  always_comb begin
    if (cmd_i.take) begin
      occ_wdata = occ_rd_q | (ROW_W'(1) << tgt_col);
    end else begin
      occ_wdata = occ_rd_q & ~(ROW_W'(1) << col_q);
    end
  end

  always_comb begin
    sum_new = sum_rd_q & ~(SUM_W'(1) << sbit);
    if (row_full_q) begin
      sum_new = sum_new | (SUM_W'(1) << sbit);
    end
  end

  // Occupancy rows: clearing sweep, updates, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_wr) begin
      occ_mem[clr_cnt_q] <= '0;
    end else if (cmd_i.take || cmd_i.drop) begin
      occ_mem[row_q] <= occ_wdata;
    end
    if (cmd_i.occ_rd) begin
      occ_rd_q <= occ_mem[row_q];
    end
  end

  // Summary rows: one full flag per occupancy row
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_wr && ((clr_cnt_q >> SR_BITS) == '0)) begin
      sum_mem[SR_BITS'(clr_cnt_q)] <= '0;
    end else if (cmd_i.sum_wr) begin
      sum_mem[srow] <= sum_new;
    end
    if (cmd_i.sum_rd) begin
      sum_rd_q <= sum_mem[srow];
    end
  end

  // Socket store
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      sock_mem[tgt_port] <= sock_q;
    end
    if (cmd_i.occ_rd) begin
      sock_rd_q <= sock_mem[port_q];
    end
  end

  // Sweep counter, top flags and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      top_full_q  <= TOP_INIT;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_wr) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (cmd_i.sum_wr) begin
        top_full_q[srow] <= &sum_new;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request, working position and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q  <= in_data_i.req_type;
      port_q <= in_port;
      lo_q   <= in_lo;
      hi_q   <= PORT_BITS'(eph_high_i);
      sock_q <= SOCKET_ID_BITS'(in_data_i.socket_handle);
      row_q  <= in_start[PORT_BITS-1:COL_BITS];
      col_q  <= in_start[COL_BITS-1:0];
    end
    if (cmd_i.row_inc) begin
      row_q <= row_q + 1'b1;
    end
    if (cmd_i.row_from_sum) begin
      row_q <= ROWS_BITS'({srow, sum_idx});
      col_q <= '0;
    end
    if (cmd_i.row_from_top) begin
      row_q <= ROWS_BITS'({top_idx, {SUMW_BITS{1'b0}}});
    end
    if (cmd_i.take) begin
      port_q     <= tgt_port;
      row_full_q <= &occ_wdata;
    end
    if (cmd_i.drop) begin
      row_full_q <= 1'b0;
    end
    if (cmd_i.set_res) begin
      res_status_q <= cmd_i.res_status;
      res_found_q  <= cmd_i.res_found;
      res_zero_q   <= cmd_i.res_zero_port;
    end
    if (cmd_i.emit) begin
      out_data_q.status       <= res_status_q;
      out_data_q.bound_port   <= res_zero_q ? '0 : FIELD_W'(port_q);
      out_data_q.found_socket <= res_found_q ? FIELD_W'(sock_rd_q) : '0;
    end
  end

  // Status to the controller
  always_comb begin
    stat_o            = '0;
    stat_o.req        = req_q;
    stat_o.clr_done   = (clr_cnt_q == ROWS_BITS'(ROWS - 1));
    stat_o.bit_set    = occ_rd_q[col_q];
    stat_o.free_found = free_found;
    stat_o.cand_ok    = ({row_q, free_idx} <= hi_q);
    stat_o.win_empty  = (lo_q > hi_q);
    stat_o.last_row   = (row_q == ROWS_BITS'(ROWS - 1));
    stat_o.sum_found  = sum_found;
    stat_o.top_found  = top_found;
    stat_o.out_busy   = out_valid_q && !out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
`default_nettype wire

// ----- rtl/core/port_binding_table.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// port_binding_table: port to socket binding table with ephemeral allocation
// Serves lookup, bind, ephemeral bind and unbind requests, one at a time.
// ----------------------------------------------------------------------------
// One request is in service at a time and each gives one result word. An
// ephemeral bind reads the occupancy row of the low bound, then at most two
// summary rows of full-row flags and one more occupancy row, each read
// through a single-port memory with registered data, and, when it takes a
// port, updates the summary. After reset the occupancy and summary memories
// are cleared one row a cycle in a sweep over the 2^(PORT_BITS-6) occupancy
// rows (1024 at 16 port bits), and no request is accepted until that pass
// ends. The ephemeral window registers lie at APB byte addresses 0 (low) and
// 4 (high); write them only while the block is idle. The result register
// lets the next request in while a result waits to be taken.
// ----------------------------------------------------------------------------
module port_binding_table import pbt_pkg::*; #(
  parameter int PORT_BITS      = PORT_BITS_DEF,
  parameter int SOCKET_ID_BITS = SOCKET_ID_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // Request channel
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire pbt_req_t                 in_data_i,
  // Result channel
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output pbt_rsp_t                      out_data_o,
  // Configuration port
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [CFG_ADDR_BITS-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0]    pwdata,
  output logic [CFG_DATA_W-1:0]         prdata,
  output logic                          pready
);

  localparam logic CFG_EPH_LOW  = 1'b0;
  localparam logic CFG_EPH_HIGH = 1'b1;

  logic [FIELD_W-1:0] eph_low_q;
  logic [FIELD_W-1:0] eph_high_q;
  logic               cfg_sel;
  pbt_cmd_t           cmd;
  pbt_stat_t          stat;

  // Register index from the word address
  assign cfg_sel = paddr[2];
  assign pready  = 1'b1;

  // Window registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eph_low_q  <= EPH_LOW_RESET;
      eph_high_q <= EPH_HIGH_RESET;
    end else if (psel && penable && pwrite) begin
      case (cfg_sel)
        CFG_EPH_LOW:  eph_low_q  <= pwdata[FIELD_W-1:0];
        CFG_EPH_HIGH: eph_high_q <= pwdata[FIELD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Read back
  always_comb begin
    case (cfg_sel)
      CFG_EPH_LOW:  prdata = CFG_DATA_W'(eph_low_q);
      CFG_EPH_HIGH: prdata = CFG_DATA_W'(eph_high_q);
      default:      prdata = '0;
    endcase
  end

  pbt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pbt_datapath #(
    .PORT_BITS      (PORT_BITS),
    .SOCKET_ID_BITS (SOCKET_ID_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .eph_low_i   (eph_low_q),
    .eph_high_i  (eph_high_q),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire
